@@ rtl/tiu_pkg.sv @@
// Package for the triple unranking block: field widths, table word layout
// and the elaboration-time triple count. No dependencies.
`default_nettype none

package tiu_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned IDX_W    = 28;
  localparam int unsigned MEMBER_W = 10;

  // Default size of the variable set.
  localparam int unsigned MAX_VARS_DEF = 1024;

  // Table values are kept saturated at 2**IDX_W, which is above any index.
  localparam int unsigned VAL_W = IDX_W + 1;
  localparam logic [VAL_W-1:0] VAL_SAT = {1'b1, {IDX_W{1'b0}}};

  // Number of triples taken from n items, n choose 3.
  function automatic logic [63:0] triple_count(input logic [63:0] n);
    logic [63:0] prod;
    begin
      prod = '0;
      if (n >= 64'd3) begin
        prod = (n * (n - 64'd1) * (n - 64'd2)) / 64'd6;
      end
      return prod;
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/tiu_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module tiu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/unrank_triple_index.sv @@
// An accepted item passes through the states KSTART, KSRCH, JSTART, JSRCH and LOAD in order,
// and out_valid is registered from LOAD. Only one item is worked on at a time; both binary
// searches walk the single read port of the lookup table one bit per cycle.
// An out-of-range index skips both searches and goes straight to LOAD.
// Reset is synchronous, active low; after reset the table fill writes all MAX_VARS entries,
// during which in_stall stays high. Depends on tiu_pkg and tiu_ram.
`default_nettype none

module unrank_triple_index #(
  parameter int unsigned MAX_VARS = tiu_pkg::MAX_VARS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [tiu_pkg::IDX_W-1:0]    in_flat_index,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [tiu_pkg::MEMBER_W-1:0] out_low_index,
  output logic      [tiu_pkg::MEMBER_W-1:0] out_mid_index,
  output logic      [tiu_pkg::MEMBER_W-1:0] out_high_index,
  output logic                              out_out_of_range
);

  // Width of a member value and of the bit position counter for the searches.
  localparam int unsigned KW = $clog2(MAX_VARS);
  localparam int unsigned PW = (KW > 1) ? $clog2(KW) : 1;
  localparam int unsigned VW = tiu_pkg::VAL_W;
  localparam int unsigned RW = 2 * VW;
  localparam int unsigned IW = tiu_pkg::IDX_W;
  localparam int unsigned MW = tiu_pkg::MEMBER_W;
  localparam logic [63:0] LIMIT = tiu_pkg::triple_count(64'(MAX_VARS));

  // Controller states.
  localparam logic [2:0] ST_FILL   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_KSTART = 3'd2;
  localparam logic [2:0] ST_KSRCH  = 3'd3;
  localparam logic [2:0] ST_JSTART = 3'd4;
  localparam logic [2:0] ST_JSRCH  = 3'd5;
  localparam logic [2:0] ST_LOAD   = 3'd6;

  localparam logic [KW-1:0] TOP_BIT = {1'b1, {(KW-1){1'b0}}};
  localparam logic [KW-1:0] LAST_K  = KW'(MAX_VARS - 1);

  // The table holds, for every k below MAX_VARS, the word
  // {tetrahedral(k), triangular(k)}, both saturated above the index range.
  // It is built once after reset by running sums, so no multiplier is needed:
  // tri(k+1) = tri(k) + k and tetra(k+1) = tetra(k) + tri(k).

  logic [2:0]    state_r, state_nxt;
  logic [KW-1:0] fill_cnt_r, fill_cnt_nxt;
  logic [VW-1:0] fill_tetra_r, fill_tetra_nxt;
  logic [VW-1:0] fill_tri_r, fill_tri_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] rem_r, rem_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [KW-1:0] j_r, j_nxt;
  logic [KW-1:0] i_r, i_nxt;
  logic [VW-1:0] tk_r, tk_nxt;
  logic [VW-1:0] tj_r, tj_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          oor_r, oor_nxt;

  logic [MW-1:0] out_low_r, out_low_nxt;
  logic [MW-1:0] out_mid_r, out_mid_nxt;
  logic [MW-1:0] out_high_r, out_high_nxt;
  logic          out_oor_r, out_oor_nxt;

  logic          ram_we;
  logic [KW-1:0] ram_raddr;
  logic [RW-1:0] ram_wdata;
  logic [RW-1:0] ram_rdata;
  logic [VW-1:0] rd_tetra;
  logic [VW-1:0] rd_tri;

  logic [VW:0]   tetra_sum;
  logic [VW:0]   tri_sum;
  logic [KW-1:0] bit_sel;
  logic [KW-1:0] cand_k;
  logic [KW-1:0] cand_j;
  logic          k_take;
  logic          j_take;
  logic          in_xfer;
  logic          out_free;

  // Keeps a candidate address inside the table; an address at or above
  // MAX_VARS is never taken by the search, so its data does not matter.
  function automatic logic [KW-1:0] clamp_addr(input logic [KW-1:0] a);
    logic [KW-1:0] r;
    begin
      r = a;
      if (32'(a) >= MAX_VARS) begin
        r = '0;
      end
      return r;
    end
  endfunction

  tiu_ram #(
    .WIDTH(RW),
    .DEPTH(MAX_VARS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(fill_cnt_r),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_tetra  = ram_rdata[RW-1:VW];
  assign rd_tri    = ram_rdata[VW-1:0];
  assign ram_wdata = {fill_tetra_r, fill_tri_r};
  assign ram_we    = (state_r == ST_FILL);

  // Running sums for the fill, clamped at the saturation value.
  assign tetra_sum = {1'b0, fill_tetra_r} + {1'b0, fill_tri_r};
  assign tri_sum   = {1'b0, fill_tri_r} + (VW+1)'(fill_cnt_r);

  // The bit under test in the current search step; the read data in this
  // cycle belongs to the candidate with this bit set.
  assign bit_sel = TOP_BIT >> pos_r;
  assign cand_k  = k_r | bit_sel;
  assign cand_j  = j_r | bit_sel;
  assign k_take  = (32'(cand_k) < MAX_VARS) && (rd_tetra <= {1'b0, idx_r});
  assign j_take  = (cand_j < k_r) && (rd_tri <= {1'b0, rem_r});

  // Only one item is worked on at a time; the input side is free whenever
  // the controller is idle, even while a finished result waits at the output.
  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    fill_cnt_nxt   = fill_cnt_r;
    fill_tetra_nxt = fill_tetra_r;
    fill_tri_nxt   = fill_tri_r;
    out_valid_nxt  = out_valid_r;
    idx_nxt        = idx_r;
    rem_nxt        = rem_r;
    k_nxt          = k_r;
    j_nxt          = j_r;
    i_nxt          = i_r;
    tk_nxt         = tk_r;
    tj_nxt         = tj_r;
    pos_nxt        = pos_r;
    oor_nxt        = oor_r;
    out_low_nxt    = out_low_r;
    out_mid_nxt    = out_mid_r;
    out_high_nxt   = out_high_r;
    out_oor_nxt    = out_oor_r;
    ram_raddr      = '0;

    // A result leaves when the downstream side takes the transfer.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_FILL: begin
        fill_cnt_nxt   = fill_cnt_r + KW'(1);
        fill_tetra_nxt = (tetra_sum >= {1'b0, tiu_pkg::VAL_SAT}) ? tiu_pkg::VAL_SAT
                                                                 : tetra_sum[VW-1:0];
        fill_tri_nxt   = (tri_sum >= {1'b0, tiu_pkg::VAL_SAT}) ? tiu_pkg::VAL_SAT
                                                               : tri_sum[VW-1:0];
        if (fill_cnt_r == LAST_K) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          idx_nxt = in_flat_index;
          k_nxt   = '0;
          j_nxt   = '0;
          tk_nxt  = '0;
          tj_nxt  = '0;
          pos_nxt = '0;
          if ({{(64-IW){1'b0}}, in_flat_index} >= LIMIT) begin
            oor_nxt   = 1'b1;
            state_nxt = ST_LOAD;
          end else begin
            oor_nxt   = 1'b0;
            state_nxt = ST_KSTART;
          end
        end
      end
      ST_KSTART: begin
        ram_raddr = clamp_addr(TOP_BIT);
        state_nxt = ST_KSRCH;
      end
      ST_KSRCH: begin
        if (k_take) begin
          k_nxt  = cand_k;
          tk_nxt = rd_tetra;
        end
        if (pos_r == PW'(KW - 1)) begin
          rem_nxt   = idx_r - tk_nxt[IW-1:0];
          pos_nxt   = '0;
          state_nxt = ST_JSTART;
        end else begin
          pos_nxt   = pos_r + PW'(1);
          ram_raddr = clamp_addr(k_nxt | (bit_sel >> 1));
        end
      end
      ST_JSTART: begin
        ram_raddr = clamp_addr(TOP_BIT);
        state_nxt = ST_JSRCH;
      end
      ST_JSRCH: begin
        if (j_take) begin
          j_nxt  = cand_j;
          tj_nxt = rd_tri;
        end
        if (pos_r == PW'(KW - 1)) begin
          i_nxt     = KW'(rem_r - tj_nxt[IW-1:0]);
          state_nxt = ST_LOAD;
        end else begin
          pos_nxt   = pos_r + PW'(1);
          ram_raddr = clamp_addr(j_nxt | (bit_sel >> 1));
        end
      end
      ST_LOAD: begin
        // Hand the result to the output register once it is free.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_oor_nxt   = oor_r;
          out_low_nxt   = oor_r ? '0 : MW'(i_r);
          out_mid_nxt   = oor_r ? '0 : MW'(j_r);
          out_high_nxt  = oor_r ? '0 : MW'(k_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_FILL;
      fill_cnt_r   <= '0;
      fill_tetra_r <= '0;
      fill_tri_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_cnt_r   <= fill_cnt_nxt;
      fill_tetra_r <= fill_tetra_nxt;
      fill_tri_r   <= fill_tri_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Working values and the result payload.
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    rem_r      <= rem_nxt;
    k_r        <= k_nxt;
    j_r        <= j_nxt;
    i_r        <= i_nxt;
    tk_r       <= tk_nxt;
    tj_r       <= tj_nxt;
    pos_r      <= pos_nxt;
    oor_r      <= oor_nxt;
    out_low_r  <= out_low_nxt;
    out_mid_r  <= out_mid_nxt;
    out_high_r <= out_high_nxt;
    out_oor_r  <= out_oor_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_low_index    = out_low_r;
  assign out_mid_index    = out_mid_r;
  assign out_high_index   = out_high_r;
  assign out_out_of_range = out_oor_r;

  // An out-of-range result carries zero members.
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_oor_r |->
      (out_low_r == '0) && (out_mid_r == '0) && (out_high_r == '0))
    else $error("out-of-range result with nonzero members");

  // A valid triple is strictly ordered when its members fit the fields.
  a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_oor_r && (MAX_VARS <= 1024) |->
      (out_low_r < out_mid_r) && (out_mid_r < out_high_r))
    else $error("result triple is not strictly increasing");

  // The second search never reaches the first search's member.
  a_j_below_k: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) && !oor_r |-> (j_r < k_r))
    else $error("middle member not below largest member");

  // A new result only appears from the load step.
  a_load_source: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r ##1 out_valid_r |-> ($past(state_r) == ST_LOAD))
    else $error("result appeared outside the load step");

  // The first search never accepts a member past the table.
  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_KSRCH) || (state_r == ST_JSRCH) |-> (32'(k_r) < MAX_VARS))
    else $error("largest member beyond the variable count");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for unrank_triple_index: drives flat ranks and checks each
// returned triple (i, j, k) and its range flag against an internal unranking predictor.
// Depends on tiu_pkg and the unrank_triple_index RTL.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // The block under test runs at its default size; the predictor uses the same value.
  localparam int unsigned MAX_VARS = tiu_pkg::MAX_VARS_DEF;

  // Time that one item spends inside the block when the output does not stall.
  localparam int unsigned ITEM_CYCLES = 2 * $clog2(MAX_VARS) + 4;

  // Length of the deliberate output back-pressure stretch.
  localparam int unsigned HOLD_CYCLES = 400;

  // Watchdog limit. The slowest correct run is roughly the table fill after reset,
  // plus about 550 items at the item cycles, plus the sender gaps, plus the receiver
  // stalls at 82 percent, plus the long hold.
  localparam int unsigned CYCLE_LIMIT = 400000;

  localparam int unsigned RANDOM_ITEMS = 530;

  // Phases of the idling schedule. The receiver idles often in the first phase and
  // the sender in the second. In the last phase neither side idles.
  typedef enum logic [1:0] {
    PH_SEND_SLOW,
    PH_RECV_SLOW,
    PH_STEADY
  } pace_phase_t;

  // One pending rank together with the way it is to be offered.
  typedef struct {
    logic [tiu_pkg::IDX_W-1:0] rank;
    pace_phase_t               phase;
    logic                      drain_first;  // wait until every expected triple has arrived
    logic                      start_hold;   // start the long receiver hold-off with this item
  } rank_item_t;

  // One expected result: the triple members and the out-of-range flag.
  typedef struct packed {
    logic [tiu_pkg::MEMBER_W-1:0] lo_member;
    logic [tiu_pkg::MEMBER_W-1:0] mid_member;
    logic [tiu_pkg::MEMBER_W-1:0] hi_member;
    logic                         past_end;
  } triple_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [tiu_pkg::IDX_W-1:0]    in_flat_index;
  logic                         out_valid;
  logic                         out_stall;
  logic [tiu_pkg::MEMBER_W-1:0] out_low_index;
  logic [tiu_pkg::MEMBER_W-1:0] out_mid_index;
  logic [tiu_pkg::MEMBER_W-1:0] out_high_index;
  logic                         out_out_of_range;

  rank_item_t  pending_ranks[$];
  triple_t     expected_triples[$];

  pace_phase_t recv_phase;
  logic        in_took;
  int unsigned hold_token;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned triples_checked;
  int unsigned past_end_checked;
  int unsigned input_held_cycles;

  unrank_triple_index #(
    .MAX_VARS(MAX_VARS)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_flat_index   (in_flat_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_low_index   (out_low_index),
    .out_mid_index   (out_mid_index),
    .out_high_index  (out_high_index),
    .out_out_of_range(out_out_of_range)
  );

  // Tetrahedral number k(k-1)(k-2)/6. This is the number of triples whose largest
  // member is below k.
  function automatic longint unsigned tetra_num(input longint unsigned k);
    if (k < 3) begin
      return 0;
    end
    return k * (k - 1) * (k - 2) / 6;
  endfunction

  // Triangular number j(j-1)/2. This is the number of pairs whose larger member is
  // below j.
  function automatic longint unsigned tri_num(input longint unsigned j);
    if (j < 2) begin
      return 0;
    end
    return j * (j - 1) / 2;
  endfunction

  localparam longint unsigned TRIPLE_TOTAL = tetra_num(64'(MAX_VARS));

  // Turns a flat rank into its triple. The predictor first takes the largest k with
  // tetra(k) <= rank. It then takes the largest j below k with tri(j) <= the remainder.
  // The member i is what remains after that. Both members are found bit by bit from
  // the top, so the search is exact.
  function automatic triple_t unrank_rank(input logic [tiu_pkg::IDX_W-1:0] rank);
    triple_t          t;
    longint unsigned  r;
    longint unsigned  k;
    longint unsigned  j;
    longint unsigned  cand;
    longint unsigned  rest;
    int               b;
    t = '0;
    r = 64'(rank);
    if (r >= TRIPLE_TOTAL) begin
      t.past_end = 1'b1;
      return t;
    end
    k = 0;
    for (b = 16; b >= 0; b--) begin
      cand = k | (64'd1 << b);
      if (cand < MAX_VARS && tetra_num(cand) <= r) begin
        k = cand;
      end
    end
    rest = r - tetra_num(k);
    j = 0;
    for (b = 16; b >= 0; b--) begin
      cand = j | (64'd1 << b);
      if (cand < k && tri_num(cand) <= rest) begin
        j = cand;
      end
    end
    rest = rest - tri_num(j);
    t.lo_member  = rest[tiu_pkg::MEMBER_W-1:0];
    t.mid_member = j[tiu_pkg::MEMBER_W-1:0];
    t.hi_member  = k[tiu_pkg::MEMBER_W-1:0];
    return t;
  endfunction

  function automatic int unsigned sender_idle_pct(input pace_phase_t ph);
    case (ph)
      PH_SEND_SLOW: return 34;
      PH_RECV_SLOW: return 82;
      default:      return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_idle_pct(input pace_phase_t ph);
    case (ph)
      PH_SEND_SLOW: return 82;
      PH_RECV_SLOW: return 34;
      default:      return 0;
    endcase
  endfunction

  function automatic void queue_rank(input longint unsigned rank, input pace_phase_t ph,
                                     input logic drain, input logic hold);
    rank_item_t item;
    item.rank        = rank[tiu_pkg::IDX_W-1:0];
    item.phase       = ph;
    item.drain_first = drain;
    item.start_hold  = hold;
    pending_ranks.push_back(item);
  endfunction

  task automatic report_field(input string name, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Free-running clock, 12 ns period.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Input driver. A new rank goes out at a falling edge only when the channel is
  // empty or the previous transfer completed at the last rising edge, so a payload
  // that is held off never changes. Whether the sender offers a rank is decided by
  // the idling schedule and never by in_stall. A rank marked to drain first
  // waits until every expected triple has been returned.
  always @(negedge clk) begin : drive_ranks
    rank_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_ranks.size() != 0
          && !(pending_ranks[0].drain_first && expected_triples.size() != 0)
          && $urandom_range(0, 99) >= sender_idle_pct(pending_ranks[0].phase)) begin
        nxt = pending_ranks.pop_front();
        in_valid      <= 1'b1;
        in_flat_index <= nxt.rank;
        recv_phase    <= nxt.phase;
        if (nxt.start_hold) begin
          hold_token <= hold_token + 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side stall. A new hold token from the driver starts a long hold-off. This
  // process counts the hold-off itself while the sender keeps offering ranks, so the
  // block fills up and has to stall its input. Outside a hold-off the stall follows
  // the idling schedule of the rank that was most recently offered.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < receiver_idle_pct(recv_phase));
    end
  end

  // Scoreboard. Everything is sampled at the rising edge. An input transfer pushes
  // its predicted triple. A result transfer is compared with the oldest prediction,
  // field by field.
  always @(posedge clk) begin : check_triples
    triple_t want;
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && in_stall && hold_left != 0) begin
      input_held_cycles++;
    end
    if (rst_n && in_valid && !in_stall) begin
      expected_triples.push_back(unrank_rank(in_flat_index));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_triples.size() == 0) begin
        $display("%0t: result transfer with none expected, actual (%0d, %0d, %0d) flag %0d",
                 $time, out_low_index, out_mid_index, out_high_index, out_out_of_range);
        fail_count++;
      end else begin
        want = expected_triples.pop_front();
        report_field("low_index", 32'(want.lo_member), 32'(out_low_index));
        report_field("mid_index", 32'(want.mid_member), 32'(out_mid_index));
        report_field("high_index", 32'(want.hi_member), 32'(out_high_index));
        report_field("out_of_range", 32'(want.past_end), 32'(out_out_of_range));
        triples_checked++;
        if (want.past_end) begin
          past_end_checked++;
        end
      end
    end
  end

  // Watchdog. It ends the run as a failure if the run goes on far longer than the
  // slowest correct run could.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: watchdog expired with %0d ranks unsent and %0d triples outstanding",
               $time, pending_ranks.size(), expected_triples.size());
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin : run_test
    longint unsigned  corner[$];
    longint unsigned  k;
    longint unsigned  j;
    longint unsigned  i;
    longint unsigned  rank;
    pace_phase_t      ph;
    int unsigned      n;
    int unsigned      sel;

    // Every input is known from time zero, and reset starts asserted.
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_flat_index     = '0;
    out_stall         = 1'b0;
    in_took           = 1'b0;
    recv_phase        = PH_SEND_SLOW;
    hold_token        = 0;
    hold_seen         = 0;
    hold_left         = 0;
    cycle_count       = 0;
    fail_count        = 0;
    triples_checked   = 0;
    past_end_checked  = 0;
    input_held_cycles = 0;

    // The directed corners come first. They cover rank zero, which gives (0, 1, 2).
    // They cover the ranks on both sides of the points where k steps up, for both
    // small and large k. They cover the last valid rank and the first ranks past the
    // end, which must raise the flag and zero the members. They also cover the all-ones
    // index, the rank at the top bit, and alternating bit patterns.
    corner = '{0, 1, 2, 3, 4, 9, 10, 19, 20,
               tetra_num(512) - 1, tetra_num(512),
               tetra_num(MAX_VARS - 1) - 1, tetra_num(MAX_VARS - 1),
               TRIPLE_TOTAL - 1, TRIPLE_TOTAL, TRIPLE_TOTAL + 1,
               (64'd1 << (tiu_pkg::IDX_W - 1)) - 1, 64'd1 << (tiu_pkg::IDX_W - 1),
               28'h5555555, 28'hAAAAAAA, (64'd1 << tiu_pkg::IDX_W) - 1};
    foreach (corner[c]) begin
      queue_rank(corner[c], PH_SEND_SLOW, 1'b0, 1'b0);
    end

    // The random part has four kinds of rank. Half are uniform over the valid ranks.
    // Others are built from a random triple, often with i at an edge of its range, or are
    // small ranks where k is low. The last part lies past the end. The sender drains
    // the block at the start of each new idling phase. One rank in the steady phase
    // starts the long receiver hold-off.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      ph = (n < 180) ? PH_SEND_SLOW : (n < 360) ? PH_RECV_SLOW : PH_STEADY;
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        rank = 64'($urandom_range(0, 32'(TRIPLE_TOTAL - 1)));
      end else if (sel < 65) begin
        k = 64'($urandom_range(2, MAX_VARS - 1));
        j = 64'($urandom_range(1, 32'(k - 1)));
        case ($urandom_range(0, 2))
          0:       i = 0;
          1:       i = j - 1;
          default: i = 64'($urandom_range(0, 32'(j - 1)));
        endcase
        rank = tetra_num(k) + tri_num(j) + i;
      end else if (sel < 80) begin
        rank = 64'($urandom_range(0, 5000));
      end else begin
        rank = 64'($urandom_range(32'(TRIPLE_TOTAL),
                                  32'((64'd1 << tiu_pkg::IDX_W) - 1)));
      end
      queue_rank(rank, ph, (n == 180 || n == 360), (n == 400));
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait until every rank has been accepted and every triple has come back. Then
    // keep the clock running so that a stray extra result would still be caught.
    while (pending_ranks.size() != 0 || in_valid || expected_triples.size() != 0) begin
      @(posedge clk);
    end
    repeat (2 * ITEM_CYCLES) @(posedge clk);

    if (expected_triples.size() != 0) begin
      $display("%0t: %0d expected triples never arrived", $time, expected_triples.size());
      fail_count++;
    end

    $display("summary: %0d triples checked, %0d of them past the end of the triple list,",
             triples_checked, past_end_checked);
    $display("summary: input held off %0d cycles while the result side was stalled",
             input_held_cycles);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
